// ----- hw/rtl/tsb_pkg.sv -----
`timescale 1ns / 1ps

package tsb_pkg;

    // Default store dimensions.
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;

    // Item actions.
    localparam logic ACTION_WRITE  = 1'b0;
    localparam logic ACTION_SAMPLE = 1'b1;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_BORDER_MODE   = 3'd0,
        CFG_FILTER_MODE   = 3'd1,
        CFG_EXPOSURE_GAIN = 3'd2,
        CFG_IMAGE_WIDTH   = 3'd3,
        CFG_IMAGE_HEIGHT  = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic               action;
        logic signed [23:0] u_coord;
        logic signed [23:0] v_coord;
        logic [7:0]         texel_col;
        logic [7:0]         texel_row;
        logic [15:0]        red_in;
        logic [15:0]        green_in;
        logic [15:0]        blue_in;
    } tsb_item_t;

    typedef struct packed {
        logic [15:0] red_out;
        logic [15:0] green_out;
        logic [15:0] blue_out;
    } tsb_result_t;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } texel_t;

    typedef struct packed {
        logic        border_mode;
        logic        filter_mode;
        logic [15:0] exposure_gain;
        logic [8:0]  image_width;
        logic [8:0]  image_height;
    } tsb_cfg_t;

    // Bilinear weights in Q1.32, four corners.
    typedef struct packed {
        logic [32:0] w00;
        logic [32:0] w01;
        logic [32:0] w10;
        logic [32:0] w11;
    } weights_t;

    // Parity of each corner index, selects the bank that holds it.
    typedef struct packed {
        logic x0p;
        logic x1p;
        logic y0p;
        logic y1p;
    } bank_sel_t;

endpackage

// ----- hw/rtl/tsb_texel_bank.sv -----
`timescale 1ns / 1ps

module tsb_texel_bank
    import tsb_pkg::*;
#(
    parameter int AW = 14
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  texel_t        wr_data,
    input  logic [AW-1:0] rd_addr,
    output texel_t        rd_data
);

    texel_t mem [2**AW];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- hw/rtl/tsb_coord.sv -----
`timescale 1ns / 1ps

module tsb_coord
    import tsb_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int AW         = 14
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  tsb_item_t           item,
    input  tsb_cfg_t            cfg,
    output logic [3:0][AW-1:0]  rd_addr,
    output bank_sel_t           sel,
    output weights_t            weights,
    output logic                sample_valid,
    output logic [3:0]          wr_en,
    output logic [AW-1:0]       wr_addr,
    output texel_t              wr_data
);

    localparam int XW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int XBW = (XW > 1) ? XW - 1 : 1;
    localparam int YBW = (YW > 1) ? YW - 1 : 1;
    localparam int NWW = $clog2(MAX_WIDTH + 1);
    localparam int NHW = $clog2(MAX_HEIGHT + 1);
    localparam int PXW = 17 + NWW;
    localparam int PYW = 17 + NHW;

    logic                 s1_valid_reg;
    tsb_item_t            s1_item_reg;
    logic                 s2_valid_reg;
    tsb_item_t            s2_item_reg;
    logic [PXW-1:0]       s2_pu_reg;
    logic [PYW-1:0]       s2_pv_reg;
    logic [NWW-1:0]       s2_nw_reg;
    logic [NHW-1:0]       s2_nh_reg;

    logic [16:0]          a_fold;
    logic [16:0]          b_fold;
    logic [NWW-1:0]       n_w;
    logic [NHW-1:0]       n_h;

    logic [XW-1:0]        x0;
    logic [XW-1:0]        x1;
    logic [YW-1:0]        y0;
    logic [YW-1:0]        y1;
    logic [16:0]          wx1;
    logic [16:0]          wy1;
    logic [16:0]          wx0;
    logic [16:0]          wy0;

    // Clamp to [0,1] or keep the fraction, in Q16.
    function automatic logic [16:0] fold(input logic signed [25:0] c, input logic mode);
        logic [16:0] r;
        if (mode)
        begin
            r = {1'b0, c[15:0]};
        end
        else if (c < 26'sd0)
        begin
            r = 17'd0;
        end
        else if (c > 26'sd65536)
        begin
            r = 17'd65536;
        end
        else
        begin
            r = c[16:0];
        end
        return r;
    endfunction

    // Stage one: fold coordinates and scale by the image size.
    always_comb
    begin
        a_fold = fold({{2{s1_item_reg.u_coord[23]}}, s1_item_reg.u_coord}, cfg.border_mode);
        b_fold = fold(26'sd65536 - {{2{s1_item_reg.v_coord[23]}}, s1_item_reg.v_coord},
                      cfg.border_mode);
        if (cfg.image_width == 9'd0)
        begin
            n_w = NWW'(1);
        end
        else if (32'(cfg.image_width) > MAX_WIDTH)
        begin
            n_w = NWW'(MAX_WIDTH);
        end
        else
        begin
            n_w = NWW'(cfg.image_width);
        end
        if (cfg.image_height == 9'd0)
        begin
            n_h = NHW'(1);
        end
        else if (32'(cfg.image_height) > MAX_HEIGHT)
        begin
            n_h = NHW'(MAX_HEIGHT);
        end
        else
        begin
            n_h = NHW'(cfg.image_height);
        end
    end

    // Pipeline control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        s1_item_reg <= item;
        s2_item_reg <= s1_item_reg;
        s2_pu_reg   <= PXW'(a_fold) * PXW'(n_w);
        s2_pv_reg   <= PYW'(b_fold) * PYW'(n_h);
        s2_nw_reg   <= n_w;
        s2_nh_reg   <= n_h;
    end

    // Stage two: indices and weights along x.
    always_comb
    begin
        logic [NWW:0]   gn;
        logic [PXW:0]   sb;
        logic [NWW+1:0] g;
        logic [NWW+1:0] gm1;
        logic [NWW-1:0] nm1;
        logic [NWW-1:0] i_n;
        logic [NWW-1:0] i0;
        logic [NWW-1:0] i1;
        gn  = s2_pu_reg[PXW-1:16];
        sb  = {1'b0, s2_pu_reg} + (PXW+1)'(32768);
        g   = sb[PXW:16];
        gm1 = g - (NWW+2)'(1);
        nm1 = s2_nw_reg - NWW'(1);
        i_n = ((NWW+1)'(nm1) < gn) ? nm1 : gn[NWW-1:0];
        i1  = ((NWW+2)'(nm1) < g) ? nm1 : g[NWW-1:0];
        if (g == '0)
        begin
            i0 = '0;
        end
        else
        begin
            i0 = ((NWW+2)'(nm1) < gm1) ? nm1 : gm1[NWW-1:0];
        end
        x0  = XW'(cfg.filter_mode ? i0 : i_n);
        x1  = XW'(cfg.filter_mode ? i1 : i_n);
        wx1 = cfg.filter_mode ? {1'b0, sb[15:0]} : 17'd0;
    end

    // Stage two: indices and weights along y.
    always_comb
    begin
        logic [NHW:0]   gn;
        logic [PYW:0]   sb;
        logic [NHW+1:0] g;
        logic [NHW+1:0] gm1;
        logic [NHW-1:0] nm1;
        logic [NHW-1:0] i_n;
        logic [NHW-1:0] i0;
        logic [NHW-1:0] i1;
        gn  = s2_pv_reg[PYW-1:16];
        sb  = {1'b0, s2_pv_reg} + (PYW+1)'(32768);
        g   = sb[PYW:16];
        gm1 = g - (NHW+2)'(1);
        nm1 = s2_nh_reg - NHW'(1);
        i_n = ((NHW+1)'(nm1) < gn) ? nm1 : gn[NHW-1:0];
        i1  = ((NHW+2)'(nm1) < g) ? nm1 : g[NHW-1:0];
        if (g == '0)
        begin
            i0 = '0;
        end
        else
        begin
            i0 = ((NHW+2)'(nm1) < gm1) ? nm1 : gm1[NHW-1:0];
        end
        y0  = YW'(cfg.filter_mode ? i0 : i_n);
        y1  = YW'(cfg.filter_mode ? i1 : i_n);
        wy1 = cfg.filter_mode ? {1'b0, sb[15:0]} : 17'd0;
    end

    // Each parity bank reads whichever corner index has its parity.
    always_comb
    begin
        logic [XW-1:0] xs;
        logic [YW-1:0] ys;
        for (int b = 0; b < 4; b++)
        begin
            xs = (x0[0] == b[0]) ? x0 : x1;
            ys = (y0[0] == b[1]) ? y0 : y1;
            rd_addr[b] = {YBW'(ys >> 1), XBW'(xs >> 1)};
        end
        sel.x0p = x0[0];
        sel.x1p = x1[0];
        sel.y0p = y0[0];
        sel.y1p = y1[0];
    end

    // Corner weights.
    always_comb
    begin
        wx0 = 17'd65536 - wx1;
        wy0 = 17'd65536 - wy1;
        weights.w00 = 33'(wx0) * 33'(wy0);
        weights.w01 = 33'(wx0) * 33'(wy1);
        weights.w10 = 33'(wx1) * 33'(wy0);
        weights.w11 = 33'(wx1) * 33'(wy1);
    end

    assign sample_valid = s2_valid_reg && (s2_item_reg.action == ACTION_SAMPLE);

    // Texel writes go out in the same stage as sample reads, so order is kept.
    always_comb
    begin
        logic in_range;
        in_range = (32'(s2_item_reg.texel_col) < MAX_WIDTH)
                && (32'(s2_item_reg.texel_row) < MAX_HEIGHT);
        for (int b = 0; b < 4; b++)
        begin
            wr_en[b] = s2_valid_reg && (s2_item_reg.action == ACTION_WRITE) && in_range
                    && (s2_item_reg.texel_col[0] == b[0])
                    && (s2_item_reg.texel_row[0] == b[1]);
        end
        wr_addr = {YBW'(s2_item_reg.texel_row >> 1), XBW'(s2_item_reg.texel_col >> 1)};
        wr_data.red   = s2_item_reg.red_in;
        wr_data.green = s2_item_reg.green_in;
        wr_data.blue  = s2_item_reg.blue_in;
    end

endmodule

// ----- hw/rtl/tsb_blend.sv -----
`timescale 1ns / 1ps

module tsb_blend
    import tsb_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          sample_valid,
    input  bank_sel_t     sel,
    input  weights_t      weights,
    input  texel_t [3:0]  bank_data,
    input  logic [15:0]   exposure_gain,
    output logic          done,
    output tsb_result_t   result
);

    logic                   s3_valid_reg;
    bank_sel_t              s3_sel_reg;
    weights_t               s3_w_reg;
    logic                   s4_valid_reg;
    logic [2:0][3:0][48:0]  s4_prod_reg;
    logic                   s5_valid_reg;
    logic [2:0][15:0]       s5_acc_reg;
    logic                   s6_valid_reg;
    logic [2:0][31:0]       s6_scaled_reg;
    logic                   done_reg;
    tsb_result_t            result_reg;

    logic [3:0][47:0]       corner;
    logic [2:0][3:0][48:0]  prod;
    logic [2:0][15:0]       acc;
    logic [2:0][15:0]       sat;

    // Pick each corner from the bank of its parity.
    always_comb
    begin
        corner[0] = bank_data[{s3_sel_reg.y0p, s3_sel_reg.x0p}];
        corner[1] = bank_data[{s3_sel_reg.y1p, s3_sel_reg.x0p}];
        corner[2] = bank_data[{s3_sel_reg.y0p, s3_sel_reg.x1p}];
        corner[3] = bank_data[{s3_sel_reg.y1p, s3_sel_reg.x1p}];
        for (int k = 0; k < 3; k++)
        begin
            prod[k][0] = 49'(s3_w_reg.w00) * 49'(corner[0][k*16 +: 16]);
            prod[k][1] = 49'(s3_w_reg.w01) * 49'(corner[1][k*16 +: 16]);
            prod[k][2] = 49'(s3_w_reg.w10) * 49'(corner[2][k*16 +: 16]);
            prod[k][3] = 49'(s3_w_reg.w11) * 49'(corner[3][k*16 +: 16]);
        end
    end

    // Sum the corners and round from Q16.32 to Q16.0.
    always_comb
    begin
        logic [50:0] sum;
        for (int k = 0; k < 3; k++)
        begin
            sum = 51'(s4_prod_reg[k][0]) + 51'(s4_prod_reg[k][1])
                + 51'(s4_prod_reg[k][2]) + 51'(s4_prod_reg[k][3])
                + 51'(32'h8000_0000);
            acc[k] = sum[47:32];
        end
    end

    // Round the exposure product and saturate.
    always_comb
    begin
        logic [32:0] r;
        for (int k = 0; k < 3; k++)
        begin
            r = 33'(s6_scaled_reg[k]) + 33'(128);
            sat[k] = (r[32:24] != '0) ? 16'hFFFF : r[23:8];
        end
    end

    // Valid chain.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= sample_valid;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
            done_reg     <= s6_valid_reg;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        s3_sel_reg  <= sel;
        s3_w_reg    <= weights;
        s4_prod_reg <= prod;
        s5_acc_reg  <= acc;
        for (int k = 0; k < 3; k++)
        begin
            s6_scaled_reg[k] <= 32'(s5_acc_reg[k]) * 32'(exposure_gain);
        end
        result_reg.red_out   <= sat[2];
        result_reg.green_out <= sat[1];
        result_reg.blue_out  <= sat[0];
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- hw/rtl/texture_sampler_bilinear_unit.sv -----
`timescale 1ns / 1ps

// Texture sampler with a texel store of MAX_WIDTH x MAX_HEIGHT RGB texels.
// Input channel: an item is taken at each rising edge with start high and
// busy low; busy stays low, so one item can enter every cycle. A write item
// stores one texel and gives no result. A sample item gives one result.
// Result channel: done is high for exactly one cycle with the result on
// result; the receiver takes it in that cycle and cannot stall the block.
// Path: a sample item passes the stage registers s1 to s6, then the output register.
// Throughput: one item per cycle. The store is split into four banks by the
// parity of column and row, so the four bilinear corners are read in the same
// cycle; writes use the same pipeline stage as reads, keeping item order.
// Configuration: cfg_write with cfg_index and cfg_data writes one register
// at the clock edge; write only while no sample is in flight.
// Reset: rst_n clears the pipeline and sets the registers to repeat mode,
// bilinear filter, unit gain and full image size. Texel contents are not
// cleared; a texel must be written before it is sampled.
module texture_sampler_bilinear_unit
    import tsb_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  tsb_item_t    item,
    output logic         done,
    output tsb_result_t  result,
    input  logic         cfg_write,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    localparam int XW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int XBW = (XW > 1) ? XW - 1 : 1;
    localparam int YBW = (YW > 1) ? YW - 1 : 1;
    localparam int AW  = XBW + YBW;

    tsb_cfg_t            cfg_reg;
    logic [3:0][AW-1:0]  rd_addr;
    bank_sel_t           sel;
    weights_t            weights;
    logic                sample_valid;
    logic [3:0]          wr_en;
    logic [AW-1:0]       wr_addr;
    texel_t              wr_data;
    texel_t [3:0]        bank_data;

    assign busy = 1'b0;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.border_mode   <= 1'b1;
            cfg_reg.filter_mode   <= 1'b1;
            cfg_reg.exposure_gain <= 16'd256;
            cfg_reg.image_width   <= 9'd256;
            cfg_reg.image_height  <= 9'd256;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_BORDER_MODE:   cfg_reg.border_mode   <= cfg_data[0];
                CFG_FILTER_MODE:   cfg_reg.filter_mode   <= cfg_data[0];
                CFG_EXPOSURE_GAIN: cfg_reg.exposure_gain <= cfg_data;
                CFG_IMAGE_WIDTH:   cfg_reg.image_width   <= cfg_data[8:0];
                CFG_IMAGE_HEIGHT:  cfg_reg.image_height  <= cfg_data[8:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    tsb_coord #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .AW         (AW)
    ) u_coord (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (start && !busy),
        .item         (item),
        .cfg          (cfg_reg),
        .rd_addr      (rd_addr),
        .sel          (sel),
        .weights      (weights),
        .sample_valid (sample_valid),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data)
    );

    // Four parity banks: index is {row parity, column parity}.
    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        tsb_texel_bank #(
            .AW (AW)
        ) u_bank (
            .clk     (clk),
            .wr_en   (wr_en[b]),
            .wr_addr (wr_addr),
            .wr_data (wr_data),
            .rd_addr (rd_addr[b]),
            .rd_data (bank_data[b])
        );
    end

    tsb_blend u_blend (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample_valid  (sample_valid),
        .sel           (sel),
        .weights       (weights),
        .bank_data     (bank_data),
        .exposure_gain (cfg_reg.exposure_gain),
        .done          (done),
        .result        (result)
    );

endmodule

// ----- tb/texture_sampler_bilinear_checker.sv -----
`timescale 1ns / 1ps

module texture_sampler_bilinear_checker
    import tsb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic         busy,
    input  tsb_item_t    item,
    input  logic         done,
    input  tsb_result_t  result,
    input  logic         cfg_write,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    output int           fail_count,
    output int           pending
);

    localparam longint ONE_Q16 = 65536;

    // Shadow copy of the texel store and the registers.
    texel_t      texel_mirror [0:MAX_WIDTH_DEF*MAX_HEIGHT_DEF-1];
    tsb_cfg_t    cfg_mirror;
    tsb_result_t expected_colors [$];
    int          fails;

    function automatic longint clamp_range(longint v, longint lo, longint hi);
        if (v < lo)
        begin
            return lo;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    // Clamp to the unit range or wrap to the fraction.
    function automatic longint fold_coord(longint c);
        if (cfg_mirror.border_mode == 1'b0)
        begin
            return clamp_range(c, 0, ONE_Q16);
        end
        return c & 64'hFFFF;
    endfunction

    // Split a half-texel shifted position into two clamped indices and a weight.
    function automatic void split_axis(input longint pos, input longint n,
                                       output longint i0, output longint i1,
                                       output longint w1);
        longint s;
        longint f;
        s  = pos * n - 32768 + ONE_Q16;
        f  = (s >>> 16) - 1;
        w1 = s & 64'hFFFF;
        i0 = clamp_range(f, 0, n - 1);
        i1 = clamp_range(f + 1, 0, n - 1);
    endfunction

    function automatic logic [15:0] blend_channel(longint unsigned w00, longint unsigned w01,
                                                  longint unsigned w10, longint unsigned w11,
                                                  logic [15:0] t00, logic [15:0] t01,
                                                  logic [15:0] t10, logic [15:0] t11);
        longint unsigned sum;
        sum = w00 * t00 + w01 * t01 + w10 * t10 + w11 * t11;
        return 16'((sum + 64'h8000_0000) >> 32);
    endfunction

    // Exposure scaling with round half up and saturation.
    function automatic logic [15:0] apply_exposure(logic [15:0] c);
        longint unsigned r;
        r = (longint'(c) * longint'(cfg_mirror.exposure_gain) + 128) >> 8;
        return (r > 65535) ? 16'hFFFF : 16'(r);
    endfunction

    function automatic tsb_result_t sample_texels(tsb_item_t it);
        longint      w, h, a, b, i, j;
        longint      x0, x1, y0, y1, wx1, wy1;
        longint unsigned w00, w01, w10, w11;
        texel_t      t00, t01, t10, t11;
        texel_t      c;
        tsb_result_t r;
        w = clamp_range(longint'(cfg_mirror.image_width), 1, MAX_WIDTH_DEF);
        h = clamp_range(longint'(cfg_mirror.image_height), 1, MAX_HEIGHT_DEF);
        a = fold_coord(longint'(it.u_coord));
        b = fold_coord(ONE_Q16 - longint'(it.v_coord));
        if (cfg_mirror.filter_mode == 1'b0)
        begin
            i = clamp_range((a * w) >>> 16, 0, w - 1);
            j = clamp_range((b * h) >>> 16, 0, h - 1);
            c = texel_mirror[j * MAX_WIDTH_DEF + i];
        end
        else
        begin
            split_axis(a, w, x0, x1, wx1);
            split_axis(b, h, y0, y1, wy1);
            w00 = (ONE_Q16 - wx1) * (ONE_Q16 - wy1);
            w01 = (ONE_Q16 - wx1) * wy1;
            w10 = wx1 * (ONE_Q16 - wy1);
            w11 = wx1 * wy1;
            t00 = texel_mirror[y0 * MAX_WIDTH_DEF + x0];
            t01 = texel_mirror[y1 * MAX_WIDTH_DEF + x0];
            t10 = texel_mirror[y0 * MAX_WIDTH_DEF + x1];
            t11 = texel_mirror[y1 * MAX_WIDTH_DEF + x1];
            c.red   = blend_channel(w00, w01, w10, w11, t00.red, t01.red, t10.red, t11.red);
            c.green = blend_channel(w00, w01, w10, w11,
                                    t00.green, t01.green, t10.green, t11.green);
            c.blue  = blend_channel(w00, w01, w10, w11, t00.blue, t01.blue, t10.blue, t11.blue);
        end
        r.red_out   = apply_exposure(c.red);
        r.green_out = apply_exposure(c.green);
        r.blue_out  = apply_exposure(c.blue);
        return r;
    endfunction

    // Track registers and items in order, and compare each result with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        tsb_result_t want;
        if (!rst_n)
        begin
            cfg_mirror.border_mode   = 1'b1;
            cfg_mirror.filter_mode   = 1'b1;
            cfg_mirror.exposure_gain = 16'd256;
            cfg_mirror.image_width   = 9'd256;
            cfg_mirror.image_height  = 9'd256;
            expected_colors.delete();
            fails = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_BORDER_MODE:   cfg_mirror.border_mode   = cfg_data[0];
                    CFG_FILTER_MODE:   cfg_mirror.filter_mode   = cfg_data[0];
                    CFG_EXPOSURE_GAIN: cfg_mirror.exposure_gain = cfg_data;
                    CFG_IMAGE_WIDTH:   cfg_mirror.image_width   = cfg_data[8:0];
                    CFG_IMAGE_HEIGHT:  cfg_mirror.image_height  = cfg_data[8:0];
                    default: ;
                endcase
            end
            if (done)
            begin
                if (expected_colors.size() == 0)
                begin
                    $error("result with no sample item outstanding");
                    fails++;
                end
                else
                begin
                    want = expected_colors.pop_front();
                    if (result.red_out !== want.red_out)
                    begin
                        $error("red_out expected %0d actual %0d", want.red_out, result.red_out);
                        fails++;
                    end
                    if (result.green_out !== want.green_out)
                    begin
                        $error("green_out expected %0d actual %0d",
                               want.green_out, result.green_out);
                        fails++;
                    end
                    if (result.blue_out !== want.blue_out)
                    begin
                        $error("blue_out expected %0d actual %0d", want.blue_out, result.blue_out);
                        fails++;
                    end
                end
            end
            if (start && !busy)
            begin
                if (item.action == ACTION_WRITE)
                begin
                    texel_mirror[{item.texel_row, item.texel_col}] =
                        {item.red_in, item.green_in, item.blue_in};
                end
                else
                begin
                    expected_colors.push_back(sample_texels(item));
                end
            end
            fail_count <= fails;
            pending    <= expected_colors.size();
        end
    end

endmodule

// ----- tb/texture_sampler_bilinear_unit_tb.sv -----
`timescale 1ns / 1ps

module texture_sampler_bilinear_unit_tb;
    import tsb_pkg::*;

    localparam int           CYCLE_LIMIT      = 1000000;
    localparam int           DRAIN_CYCLES     = 20;
    localparam logic [2:0]   CFG_INDEX_UNUSED = 3'd5;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    tsb_item_t   item;
    logic        done;
    tsb_result_t result;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    int          fail_count;
    int          pending;

    bit          written_map [0:MAX_WIDTH_DEF*MAX_HEIGHT_DEF-1];
    int          cycle_count;
    int          sample_count;
    int          write_count;
    int          phase_count;
    bit          gaps_on;
    logic [8:0]  width_reg;
    logic [8:0]  height_reg;

    texture_sampler_bilinear_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    texture_sampler_bilinear_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .item       (item),
        .done       (done),
        .result     (result),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("texture_sampler_bilinear_unit verification failed");
            $finish;
        end
    end

    // Present one item, after a random gap if gaps are on, and hold it until it is taken.
    task automatic send_item(tsb_item_t it);
        int gap;
        gap = gaps_on ? $urandom_range(0, 17) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        if (it.action == ACTION_WRITE)
        begin
            written_map[{it.texel_row, it.texel_col}] = 1'b1;
            write_count++;
        end
        else
        begin
            sample_count++;
        end
    endtask

    function automatic logic [15:0] pick_channel();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [23:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return 24'($urandom);
            1:
            begin
                case ($urandom_range(0, 5))
                    0:       return 24'sh800000;
                    1:       return 24'sh7FFFFF;
                    2:       return 24'sd0;
                    3:       return 24'sd65536;
                    4:       return 24'sd65535;
                    default: return 24'sd32768;
                endcase
            end
            default: return 24'(int'($urandom_range(0, 98304)) - 16384);
        endcase
    endfunction

    function automatic tsb_item_t make_write(int col, int row);
        tsb_item_t it;
        it.action    = ACTION_WRITE;
        it.u_coord   = 24'($urandom);
        it.v_coord   = 24'($urandom);
        it.texel_col = 8'(col);
        it.texel_row = 8'(row);
        it.red_in    = pick_channel();
        it.green_in  = pick_channel();
        it.blue_in   = pick_channel();
        return it;
    endfunction

    function automatic tsb_item_t make_sample(logic signed [23:0] u, logic signed [23:0] v);
        tsb_item_t it;
        it           = make_write($urandom_range(0, 255), $urandom_range(0, 255));
        it.action    = ACTION_SAMPLE;
        it.u_coord   = u;
        it.v_coord   = v;
        return it;
    endfunction

    // Let all outstanding samples come back, then wait DRAIN_CYCLES for trailing writes.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        if (idx == CFG_IMAGE_WIDTH)
        begin
            width_reg = data[8:0];
        end
        if (idx == CFG_IMAGE_HEIGHT)
        begin
            height_reg = data[8:0];
        end
    endtask

    // Idle block only: set all five registers, then drop the write enable.
    task automatic set_mode(logic border, logic filter, logic [15:0] gain,
                            logic [8:0] w, logic [8:0] h);
        write_reg(CFG_BORDER_MODE, {15'($urandom), border});
        write_reg(CFG_FILTER_MODE, {15'($urandom), filter});
        write_reg(CFG_EXPOSURE_GAIN, gain);
        write_reg(CFG_IMAGE_WIDTH, {7'($urandom), w});
        write_reg(CFG_IMAGE_HEIGHT, {7'($urandom), h});
        if ($urandom_range(0, 2) == 0)
        begin
            write_reg(CFG_INDEX_UNUSED, 16'($urandom));
        end
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Make sure every texel inside the active image has been written.
    task automatic fill_image();
        int w;
        int h;
        w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg);
        h = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : height_reg);
        for (int r = 0; r < h; r++)
        begin
            for (int c = 0; c < w; c++)
            begin
                if (!written_map[r * MAX_WIDTH_DEF + c])
                begin
                    send_item(make_write(c, r));
                end
            end
        end
    endtask

    // Mostly samples with a share of random writes anywhere in the store.
    task automatic random_items(int count);
        for (int n = 0; n < count; n++)
        begin
            if (n == count / 2 && $urandom_range(0, 1) == 0)
            begin
                drain();
            end
            if (n % 50 == 0)
            begin
                gaps_on = ($urandom_range(0, 2) != 0);
            end
            if ($urandom_range(0, 3) == 0)
            begin
                send_item(make_write($urandom_range(0, 255), $urandom_range(0, 255)));
            end
            else
            begin
                send_item(make_sample(pick_coord(), pick_coord()));
            end
        end
        drain();
    endtask

    task automatic run_phase(logic border, logic filter, logic [15:0] gain,
                             logic [8:0] w, logic [8:0] h, int count);
        set_mode(border, filter, gain, w, h);
        fill_image();
        random_items(count);
        phase_count++;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        item         = '0;
        cfg_write    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        sample_count = 0;
        write_count  = 0;
        phase_count  = 0;
        gaps_on      = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: small image, corner coordinates and extreme texels.
        set_mode(1'b1, 1'b1, 16'd256, 9'd4, 9'd4);
        fill_image();
        send_item(make_write(255, 255));
        send_item(make_write(0, 0));
        send_item(make_sample(24'sd0, 24'sd0));
        send_item(make_sample(24'sd65536, 24'sd65536));
        send_item(make_sample(24'sd32768, 24'sd32768));
        send_item(make_sample(24'sh800000, 24'sh7FFFFF));
        send_item(make_sample(24'sh7FFFFF, 24'sh800000));
        send_item(make_sample(24'sd65535, 24'sd1));
        send_item(make_sample(-24'sd1, 24'sd65537));
        send_item(make_sample(24'sd8192, 24'sd57344));
        drain();
        set_mode(1'b0, 1'b0, 16'd256, 9'd4, 9'd4);
        send_item(make_sample(24'sh800000, 24'sh7FFFFF));
        send_item(make_sample(24'sd65536, 24'sd0));
        send_item(make_sample(24'sd0, 24'sd65536));
        send_item(make_sample(24'sd49152, 24'sd16384));
        drain();

        // Settings sweep including register extremes and out-of-range sizes.
        run_phase(1'b1, 1'b1, 16'd256, 9'd4, 9'd4, 100);
        run_phase(1'b0, 1'b1, 16'd256, 9'd5, 9'd3, 100);
        run_phase(1'b0, 1'b0, 16'd512, 9'd7, 9'd2, 100);
        run_phase(1'b1, 1'b0, 16'hFFFF, 9'd1, 9'd1, 100);
        run_phase(1'b0, 1'b1, 16'd0, 9'd16, 9'd16, 100);
        run_phase(1'b1, 1'b1, 16'd300, 9'd256, 9'd1, 100);
        run_phase(1'b0, 1'b0, 16'd256, 9'd1, 9'd256, 100);
        run_phase(1'b1, 1'b1, 16'd128, 9'd0, 9'd300, 100);
        run_phase(1'b0, 1'b1, 16'hFFFF, 9'd511, 9'd1, 100);
        for (int p = 0; p < 5; p++)
        begin
            run_phase(1'($urandom), 1'($urandom), 16'($urandom),
                      9'($urandom_range(1, 16)), 9'($urandom_range(1, 16)), 100);
        end

        drain();
        $display("Covered %0d phases of register settings: %0d samples and %0d texel writes.",
                 phase_count, sample_count, write_count);
        $display("Both border modes, both filters, gain and size extremes, random gaps.");
        if (fail_count == 0)
        begin
            $display("texture_sampler_bilinear_unit verification clean");
        end
        else
        begin
            $display("texture_sampler_bilinear_unit verification failed");
        end
        $finish;
    end

endmodule
